// ===== design/depth_first_graph_walk_macros.svh =====
// Assertion helpers for the checker file.
// Each expects i_clk and i_rst_n in scope.
`ifndef DEPTH_FIRST_GRAPH_WALK_MACROS_SVH
`define DEPTH_FIRST_GRAPH_WALK_MACROS_SVH

// same-cycle implication
`define DFGW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DFGW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dfgw_pkg.sv =====
package dfgw_pkg;

    localparam int VTX_W            = 6;   // vertex field width
    localparam int CNT_W            = 7;   // vertex_count register width
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_RUN    = 1'b1
    } t_opcode;

endpackage

// ===== design/dfgw_if.sv =====
interface dfgw_cmd_if
    import dfgw_pkg::*;
();
    logic             valid;
    logic             ready;
    t_opcode          opcode;
    logic [VTX_W-1:0] src_vertex;
    logic [VTX_W-1:0] dst_vertex;

    modport source (output valid, opcode, src_vertex, dst_vertex, input ready);
    modport sink   (input valid, opcode, src_vertex, dst_vertex, output ready);
endinterface

interface dfgw_res_if
    import dfgw_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [VTX_W-1:0] visited_vertex;
    logic             last;
    logic             bad_start;
    logic             edges_dropped;

    modport source (output valid, visited_vertex, last, bad_start, edges_dropped,
                    input ready);
    modport sink   (input valid, visited_vertex, last, bad_start, edges_dropped,
                    output ready);
endinterface

interface dfgw_cfg_if
    import dfgw_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== design/depth_first_graph_walk.sv =====
// Depth-first walk over a directed graph held as per-vertex neighbor lists.
// i_cmd: one transfer per command. opcode APPEND adds src_vertex->dst_vertex
//   at the tail of the source's list and gives no result. opcode RUN clears
//   the visited marks and walks depth first from src_vertex.
// o_res: one transfer per visited vertex in visit order, last set on the
//   final one. A bad start vertex gives one result: vertex 0, last, bad_start.
//   edges_dropped is sticky: an append with an out-of-range endpoint or with
//   the edge store full was discarded since reset.
// i_cfg: writes vertex_count (always ready); write only while idle.
// Steps: an append passes S_AWR then S_ALINK, a dropped one ends in idle, a
//   bad start goes straight to S_LAST. A run repeats the edge loop:
//   registered edge-store read, registered visited-tag read, visit
//   test. Visited marks are per-run tags; the first run after reset and every
//   255th run after it first clear the whole tag memory.
//   i_cmd.ready is low for the whole run.
// Results leave through an output register; when the receiver stalls, the
// walk stops at its next visit until the register frees. Reset empties all
// lists, clears the drop flag and sets vertex_count to 64.
module depth_first_graph_walk
    import dfgw_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dfgw_cmd_if.sink   i_cmd,
    dfgw_res_if.source o_res,
    dfgw_cfg_if.sink   i_cfg
);

    localparam int VAW = $clog2(MAX_VERTICES);     // vertex memory address
    localparam int SPW = $clog2(MAX_VERTICES + 1); // stack depth 0..MAX_VERTICES
    localparam int EAW = $clog2(MAX_EDGES);        // edge memory address
    localparam int EPW = $clog2(MAX_EDGES + 1);    // edge pointer incl. null
    localparam int TAGW = 8;                       // run tag for visited marks
    localparam logic [EPW-1:0]   NULL_E   = EPW'(MAX_EDGES);
    localparam logic [CNT_W-1:0] VMAX     = CNT_W'(MAX_VERTICES);
    localparam logic [TAGW-1:0]  TAG_LAST = '1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_AWR   = 11'b00000000010,  // write new edge, fetch tail
        S_ALINK = 11'b00000000100,  // chain old tail, update tail
        S_CLR   = 11'b00000001000,  // clear visited tags before tag wrap
        S_START = 11'b00000010000,  // load head of start vertex, mark it
        S_EDGE  = 11'b00000100000,  // look at top-of-stack edge
        S_FETCH = 11'b00001000000,  // read visited tag of edge target
        S_POP   = 11'b00010000000,  // reload top from stack memory
        S_TEST  = 11'b00100000000,  // visit test on edge target
        S_PUSH  = 11'b01000000000,  // push new vertex
        S_LAST  = 11'b10000000000   // final result
    } t_state;

    // control registers
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_vcount;
    logic                r_drop, n_drop;
    logic [EPW-1:0]      r_used, n_used;
    logic [MAX_VERTICES-1:0] r_head_vld, n_head_vld;
    logic [TAGW-1:0]     r_epoch, n_epoch;
    logic [SPW-1:0]      r_sp, n_sp;
    logic                r_ovld;

    // working payload
    logic [VTX_W-1:0]    r_src, n_src;
    logic [VTX_W-1:0]    r_dst, n_dst;
    logic [EPW-1:0]      r_top, n_top;
    logic [VTX_W-1:0]    r_pend, n_pend;
    logic                r_pbad, n_pbad;
    logic [VAW-1:0]      r_clr, n_clr;
    logic [VTX_W-1:0]    r_ovtx;
    logic                r_olast, r_obad, r_odrop;

    // memories and their registered read data
    logic [EAW-1:0]      r_head_mem [MAX_VERTICES];
    logic [EAW-1:0]      r_tail_mem [MAX_VERTICES];
    logic [VTX_W-1:0]    r_tgt_mem  [MAX_EDGES];
    logic [EPW-1:0]      r_link_mem [MAX_EDGES];
    logic [EPW-1:0]      r_stk_mem  [MAX_VERTICES];
    logic [TAGW-1:0]     r_vis_mem  [MAX_VERTICES];
    logic [EAW-1:0]      r_head_q;
    logic                r_hvld_q;
    logic [EAW-1:0]      r_tail_q;
    logic                r_had_head;
    logic [VTX_W-1:0]    r_tgt_q;
    logic [EPW-1:0]      r_link_q;
    logic [EPW-1:0]      r_stk_q;
    logic [TAGW-1:0]     r_vis_q;

    // memory port controls
    logic                head_we, head_re, tail_we, tail_re;
    logic [VAW-1:0]      head_waddr, head_raddr, tail_waddr, tail_raddr;
    logic [EAW-1:0]      head_wdata, tail_wdata;
    logic                tgt_we, link_we, edge_re, stk_we, stk_re;
    logic [EAW-1:0]      tgt_waddr, link_waddr, edge_raddr;
    logic [EPW-1:0]      link_wdata, stk_wdata;
    logic [VAW-1:0]      stk_waddr, stk_raddr;
    logic                vis_we, vis_re;
    logic [VAW-1:0]      vis_waddr, vis_raddr;
    logic [TAGW-1:0]     vis_wdata;

    logic                emit, emit_last;
    logic [CNT_W-1:0]    c_eff;
    logic                out_free, cmd_acc, src_ok, dst_ok, t_ok, top_null, clr_done;
    logic [VAW-1:0]      src_idx, t_idx, reg_src_idx, pend_idx;
    logic [SPW-1:0]      sp_m1, sp_m2;

    assign c_eff       = (r_vcount > VMAX) ? VMAX : r_vcount;
    assign out_free    = !r_ovld || o_res.ready;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign src_ok      = {1'b0, i_cmd.src_vertex} < c_eff;
    assign dst_ok      = {1'b0, i_cmd.dst_vertex} < c_eff;
    assign t_ok        = {1'b0, r_tgt_q} < c_eff;
    assign top_null    = r_top >= r_used;  // covers the null pointer too
    assign clr_done    = (r_clr == VAW'(MAX_VERTICES - 1));
    assign src_idx     = i_cmd.src_vertex[VAW-1:0];
    assign t_idx       = r_tgt_q[VAW-1:0];
    assign reg_src_idx = r_src[VAW-1:0];
    assign pend_idx    = r_pend[VAW-1:0];
    assign sp_m1       = r_sp - SPW'(1);
    assign sp_m2       = r_sp - SPW'(2);

    always_comb begin
        n_state    = r_state;
        n_drop     = r_drop;
        n_used     = r_used;
        n_head_vld = r_head_vld;
        n_epoch    = r_epoch;
        n_sp       = r_sp;
        n_src      = r_src;
        n_dst      = r_dst;
        n_top      = r_top;
        n_pend     = r_pend;
        n_pbad     = r_pbad;
        n_clr      = r_clr;
        head_we    = 1'b0;
        head_re    = 1'b0;
        head_waddr = reg_src_idx;
        head_raddr = src_idx;
        head_wdata = r_used[EAW-1:0];
        tail_we    = 1'b0;
        tail_re    = 1'b0;
        tail_waddr = reg_src_idx;
        tail_raddr = reg_src_idx;
        tail_wdata = r_used[EAW-1:0];
        tgt_we     = 1'b0;
        tgt_waddr  = r_used[EAW-1:0];
        link_we    = 1'b0;
        link_waddr = r_used[EAW-1:0];
        link_wdata = NULL_E;
        edge_re    = 1'b0;
        edge_raddr = r_top[EAW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = sp_m1[VAW-1:0];
        stk_wdata  = r_top;
        stk_re     = 1'b0;
        stk_raddr  = sp_m2[VAW-1:0];
        vis_we     = 1'b0;
        vis_re     = 1'b0;
        vis_waddr  = t_idx;
        vis_raddr  = t_idx;
        vis_wdata  = r_epoch;
        emit       = 1'b0;
        emit_last  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    if (i_cmd.opcode == OP_APPEND) begin
                        if (src_ok && dst_ok && (r_used < NULL_E)) begin
                            n_src   = i_cmd.src_vertex;
                            n_dst   = i_cmd.dst_vertex;
                            n_state = S_AWR;
                        end else begin
                            n_drop = 1'b1;
                        end
                    end else if (src_ok) begin
                        n_pend = i_cmd.src_vertex;
                        n_pbad = 1'b0;
                        if (r_epoch == TAG_LAST) begin
                            // tags used up (or never cleared): wipe them first
                            n_clr   = '0;
                            n_state = S_CLR;
                        end else begin
                            n_epoch = r_epoch + TAGW'(1);
                            head_re = 1'b1;
                            n_state = S_START;
                        end
                    end else begin
                        n_pend  = '0;
                        n_pbad  = 1'b1;
                        n_state = S_LAST;
                    end
                end
            end
            S_AWR: begin
                tgt_we  = 1'b1;
                link_we = 1'b1;
                tail_re = 1'b1;
                if (!r_head_vld[reg_src_idx]) begin
                    head_we                 = 1'b1;
                    n_head_vld[reg_src_idx] = 1'b1;
                end
                n_state = S_ALINK;
            end
            S_ALINK: begin
                if (r_had_head) begin
                    link_we    = 1'b1;
                    link_waddr = r_tail_q;
                    link_wdata = r_used;
                end
                tail_we = 1'b1;
                n_used  = r_used + EPW'(1);
                n_state = S_IDLE;
            end
            S_CLR: begin
                vis_we    = 1'b1;
                vis_waddr = r_clr;
                vis_wdata = '0;
                n_clr     = r_clr + VAW'(1);
                if (clr_done) begin
                    n_epoch    = TAGW'(1);
                    head_re    = 1'b1;
                    head_raddr = pend_idx;
                    n_state    = S_START;
                end
            end
            S_START: begin
                vis_we    = 1'b1;
                vis_waddr = pend_idx;
                n_top     = r_hvld_q ? EPW'(r_head_q) : NULL_E;
                n_sp      = SPW'(1);
                n_state   = S_EDGE;
            end
            S_EDGE: begin
                if (top_null) begin
                    n_sp = sp_m1;
                    if (r_sp == SPW'(1)) begin
                        n_state = S_LAST;
                    end else begin
                        stk_re  = 1'b1;
                        n_state = S_POP;
                    end
                end else begin
                    edge_re = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                vis_re  = 1'b1;
                n_state = S_TEST;
            end
            S_POP: begin
                n_top   = r_stk_q;
                n_state = S_EDGE;
            end
            S_TEST: begin
                if (t_ok && (r_vis_q != r_epoch)) begin
                    // new vertex: the pending one is now known not to be last
                    if (out_free) begin
                        emit       = 1'b1;
                        n_pend     = r_tgt_q;
                        vis_we     = 1'b1;
                        head_re    = 1'b1;
                        head_raddr = t_idx;
                        n_top      = r_link_q;
                        n_state    = S_PUSH;
                    end
                end else begin
                    n_top   = r_link_q;
                    n_state = S_EDGE;
                end
            end
            S_PUSH: begin
                stk_we  = 1'b1;
                n_sp    = r_sp + SPW'(1);
                n_top   = r_hvld_q ? EPW'(r_head_q) : NULL_E;
                n_state = S_EDGE;
            end
            S_LAST: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vcount   <= VCOUNT_RESET;
            r_drop     <= 1'b0;
            r_used     <= '0;
            r_head_vld <= '0;
            r_epoch    <= TAG_LAST;
            r_sp       <= '0;
            r_ovld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_drop     <= n_drop;
            r_used     <= n_used;
            r_head_vld <= n_head_vld;
            r_epoch    <= n_epoch;
            r_sp       <= n_sp;
            if (i_cfg.valid && i_cfg.ready) begin
                r_vcount <= i_cfg.data;
            end
            if (emit) begin
                r_ovld <= 1'b1;
            end else if (o_res.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_top  <= n_top;
        r_pend <= n_pend;
        r_pbad <= n_pbad;
        r_clr  <= n_clr;
        if (emit) begin
            r_ovtx  <= r_pend;
            r_olast <= emit_last;
            r_obad  <= r_pbad;
            r_odrop <= r_drop;
        end
    end

    // vertex-indexed memories
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[head_waddr] <= head_wdata;
        end
        if (head_re) begin
            r_head_q <= r_head_mem[head_raddr];
            r_hvld_q <= r_head_vld[head_raddr];
        end
        if (tail_we) begin
            r_tail_mem[tail_waddr] <= tail_wdata;
        end
        if (tail_re) begin
            r_tail_q   <= r_tail_mem[tail_raddr];
            r_had_head <= r_head_vld[tail_raddr];
        end
        if (stk_we) begin
            r_stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stk_q <= r_stk_mem[stk_raddr];
        end
        if (vis_we) begin
            r_vis_mem[vis_waddr] <= vis_wdata;
        end
        if (vis_re) begin
            r_vis_q <= r_vis_mem[vis_raddr];
        end
    end

    // edge store
    always_ff @(posedge i_clk) begin
        if (tgt_we) begin
            r_tgt_mem[tgt_waddr] <= r_dst;
        end
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        if (edge_re) begin
            r_tgt_q  <= r_tgt_mem[edge_raddr];
            r_link_q <= r_link_mem[edge_raddr];
        end
    end

    assign i_cmd.ready          = (r_state == S_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_res.valid          = r_ovld;
    assign o_res.visited_vertex = r_ovtx;
    assign o_res.last           = r_olast;
    assign o_res.bad_start      = r_obad;
    assign o_res.edges_dropped  = r_odrop;

endmodule

// ===== design/dfgw_checker.sv =====
`include "depth_first_graph_walk_macros.svh"

module dfgw_checker
    import dfgw_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cmd_valid,
    input logic             i_cmd_ready,
    input t_opcode          i_cmd_opcode,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input logic [VTX_W-1:0] i_res_vertex,
    input logic             i_res_last,
    input logic             i_res_bad
);

    // a bad start is a lone final result for vertex 0
    `DFGW_ASSERT_IMP(a_bad_start_form, i_res_valid && i_res_bad, i_res_last && (i_res_vertex == '0), "bad start result not a final zero result")

    // a run holds off commands right after it is taken
    `DFGW_ASSERT_NXT(a_run_busy, i_cmd_valid && i_cmd_ready && (i_cmd_opcode == OP_RUN), !i_cmd_ready, "command taken during a run")

    // non-final results only show while a walk is in progress
    `DFGW_ASSERT_IMP(a_mid_run_busy, i_res_valid && !i_res_last, !i_cmd_ready, "ready while a walk is unfinished")

    // stalled result holds
    `DFGW_ASSERT_NXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_vertex) && $stable(i_res_last), "stalled result changed")

endmodule

bind depth_first_graph_walk dfgw_checker u_dfgw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_cmd_opcode (i_cmd.opcode),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_vertex (o_res.visited_vertex),
    .i_res_last   (o_res.last),
    .i_res_bad    (o_res.bad_start)
);
